// File: rtl/core/hdlc_tx_framer_nrzi_defines.svh
// Assertion macros used by the HDLC transmit framer checker.
`ifndef HDLC_TX_FRAMER_NRZI_DEFINES_SVH
`define HDLC_TX_FRAMER_NRZI_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HTX_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("htx assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HTX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("htx assertion failed");

`endif

// File: rtl/core/htx_pkg.sv
// Types, constants and CRC function for the HDLC transmit framer.
`timescale 1ns / 1ps

package htx_pkg;

  localparam logic [1:0] FUNC_FLAG = 2'd0;
  localparam logic [1:0] FUNC_DATA = 2'd1;
  localparam logic [1:0] FUNC_FCS  = 2'd2;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [2:0]  STUFF_RUN = 3'd5;
  localparam logic [4:0]  MAX_RESULTS = 5'd20;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       new_packet;
  } in_t;

  typedef struct packed {
    logic line_bit;
    logic last_of_item;
  } out_t;

  // Classified work for the bit engine: bits go out LSB first.
  typedef struct packed {
    logic [15:0] bits;
    logic [4:0]  nbits;
    logic        stuff_en;
    logic        new_packet;
  } job_t;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] x;
    x = crc ^ {8'h00, b};
    for (int j = 0; j < 8; j++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// File: rtl/core/htx_front.sv
// Front end: accepts items, keeps the running FCS and builds bit jobs.
`timescale 1ns / 1ps

module htx_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  htx_pkg::in_t  in_data_i,
  input  logic          q_ready_i,
  output logic          push_o,
  output htx_pkg::job_t job_o
);

  logic [15:0] fcs_q, fcs_d;

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i & q_ready_i;

  always_comb begin
    job_o.new_packet = in_data_i.new_packet;
    job_o.bits       = 16'h0000;
    job_o.nbits      = 5'd0;
    job_o.stuff_en   = 1'b0;
    fcs_d            = fcs_q;
    case (in_data_i.func)
      htx_pkg::FUNC_FLAG: begin
        job_o.bits  = {8'h00, htx_pkg::FLAG_BYTE};
        job_o.nbits = 5'd8;
        fcs_d       = htx_pkg::CRC_INIT;
      end
      htx_pkg::FUNC_DATA: begin
        job_o.bits     = {8'h00, in_data_i.data_byte};
        job_o.nbits    = 5'd8;
        job_o.stuff_en = 1'b1;
        fcs_d          = htx_pkg::crc16_byte(fcs_q, in_data_i.data_byte);
      end
      htx_pkg::FUNC_FCS: begin
        job_o.bits     = ~fcs_q;
        job_o.nbits    = 5'd16;
        job_o.stuff_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcs_q <= htx_pkg::CRC_INIT;
    end else if (push_o) begin
      fcs_q <= fcs_d;
    end
  end

endmodule

// File: rtl/core/htx_queue.sv
// Two-entry job queue between front end and bit engine.
`timescale 1ns / 1ps

module htx_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  htx_pkg::job_t job_i,
  output logic          ready_o,
  input  logic          pop_i,
  output logic          valid_o,
  output htx_pkg::job_t job_o
);

  htx_pkg::job_t mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q, cnt_d;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
    end
  end

endmodule

// File: rtl/core/htx_back.sv
// Bit engine: serializes jobs, inserts stuffed zeros, NRZI-encodes the line.
`timescale 1ns / 1ps

module htx_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  htx_pkg::job_t job_i,
  output logic          job_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output htx_pkg::out_t out_data_o
);

  localparam logic [2:0] RunMax = htx_pkg::STUFF_RUN - 3'd1;

  logic          busy_q, busy_d;
  logic [15:0]   sr_q, sr_d;
  logic [4:0]    left_q, left_d;
  logic          pend_q, pend_d;
  logic          stuff_q, stuff_d;
  logic [2:0]    ones_q, ones_d;
  logic          level_q, level_d;
  logic          ovalid_q, ovalid_d;
  htx_pkg::out_t odata_q, odata_d;

  logic        can_emit, emit, bit_v, trig, last;
  logic [15:0] sr_e;
  logic [4:0]  left_e;
  logic        pend_e, stuff_e, level_e;
  logic [2:0]  ones_n;

  assign can_emit  = ~ovalid_q | out_ready_i;
  assign job_pop_o = ~busy_q & job_valid_i & ((job_i.nbits == 5'd0) | can_emit);
  assign emit      = can_emit & (busy_q | (job_pop_o & (job_i.nbits != 5'd0)));

  always_comb begin
    if (busy_q) begin
      sr_e    = sr_q;
      left_e  = left_q;
      pend_e  = pend_q;
      stuff_e = stuff_q;
      level_e = level_q;
    end else begin
      sr_e    = job_i.bits;
      left_e  = job_i.nbits;
      pend_e  = 1'b0;
      stuff_e = job_i.stuff_en;
      level_e = job_i.new_packet | level_q;
    end
    bit_v = ~pend_e & sr_e[0];
    trig  = ~pend_e & stuff_e & bit_v & (ones_q == RunMax);
    last  = pend_e ? (left_e == 5'd0) : ((left_e == 5'd1) & ~trig);
    if (stuff_e & bit_v & ~trig) begin
      ones_n = ones_q + 3'd1;
    end else begin
      ones_n = 3'd0;
    end
  end

  always_comb begin
    busy_d   = busy_q;
    sr_d     = sr_q;
    left_d   = left_q;
    pend_d   = pend_q;
    stuff_d  = stuff_q;
    ones_d   = ones_q;
    level_d  = level_q;
    ovalid_d = ovalid_q & ~out_ready_i;
    odata_d  = odata_q;
    if (emit) begin
      sr_d     = pend_e ? sr_e : (sr_e >> 1);
      left_d   = pend_e ? left_e : (left_e - 5'd1);
      pend_d   = trig;
      stuff_d  = stuff_e;
      ones_d   = ones_n;
      level_d  = bit_v ? level_e : ~level_e;
      busy_d   = ~last;
      ovalid_d = 1'b1;
      odata_d.line_bit     = bit_v ? level_e : ~level_e;
      odata_d.last_of_item = last;
    end else if (job_pop_o) begin
      level_d = level_e;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_d_hold: begin
      sr_q    <= sr_d;
      left_q  <= left_d;
      stuff_q <= stuff_d;
      odata_q <= odata_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      pend_q   <= 1'b0;
      ones_q   <= 3'd0;
      level_q  <= 1'b1;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      pend_q   <= pend_d;
      ones_q   <= ones_d;
      level_q  <= level_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

endmodule

// File: rtl/core/hdlc_tx_framer_nrzi.sv
// Top level of the HDLC transmit framer with FCS-16, bit stuffing and NRZI.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): one transaction per item:
// func selects flag, data byte or FCS; new_packet forces the line level to 1
// before the item. Output channel (out_valid_o/out_ready_i/out_data_o): one
// transaction per line bit; last_of_item marks the final bit of an item.
// An unused func code produces no output but still applies new_packet.
// When the bit engine is free, an accepted item passes the job queue and then
// the output register before its first bit is presented. Throughput: one line
// bit per cycle while the receiver does not stall, set by the single bit
// engine; an item gives 8 line bits (flag), 8 to 10 (data byte) or 16 to 20
// (FCS); items follow with no gap, but an unused func code gives a gap.
// A two-entry job queue sits between the front end and the bit engine, so
// input keeps flowing while the engine works; when the receiver stalls the
// output register holds its bit and the queue fills, then in_ready_o drops.
// Reset: FCS register 0xFFFF, ones count 0, line level 1, queue empty.
`timescale 1ns / 1ps

module hdlc_tx_framer_nrzi (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  htx_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output htx_pkg::out_t out_data_o
);

  logic          push, q_ready, q_valid, pop;
  htx_pkg::job_t job_in, job_out;

  htx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_ready_i  (q_ready),
    .push_o     (push),
    .job_o      (job_in)
  );

  htx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (job_out)
  );

  htx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (job_out),
    .job_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/core/htx_checker.sv
// Port-level checker for the HDLC transmit framer, bound to the top level.
`timescale 1ns / 1ps
`include "hdlc_tx_framer_nrzi_defines.svh"

module htx_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input htx_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input htx_pkg::out_t out_data_o
);

  logic       in_acc, out_acc, out_last;
  logic [3:0] open_q;
  logic [4:0] run_q;

  assign in_acc   = in_valid_i & in_ready_o &
                    ((in_data_i.func == htx_pkg::FUNC_FLAG) ||
                     (in_data_i.func == htx_pkg::FUNC_DATA) ||
                     (in_data_i.func == htx_pkg::FUNC_FCS));
  assign out_acc  = out_valid_o & out_ready_i;
  assign out_last = out_acc & out_data_o.last_of_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 4'd0;
      run_q  <= 5'd0;
    end else begin
      open_q <= open_q + {3'd0, in_acc} - {3'd0, out_last};
      if (out_last) begin
        run_q <= 5'd0;
      end else if (out_acc) begin
        run_q <= run_q + 5'd1;
      end
    end
  end

  `HTX_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `HTX_ASSERT_SAME(a_out_has_item, out_valid_o, open_q != 4'd0)
  `HTX_ASSERT_SAME(a_run_bound, out_acc, run_q < htx_pkg::MAX_RESULTS)
  `HTX_ASSERT_SAME(a_open_bound, 1'b1, open_q < 4'd5)

endmodule

bind hdlc_tx_framer_nrzi htx_checker u_htx_checker (.*);

// File: verif/tb_top.sv
// Self-checking testbench for the HDLC transmit framer: flags, stuffed data, FCS and NRZI.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] FUNC_NONE = 2'd3;

  typedef struct {
    htx_pkg::in_t item;
    int unsigned  gap;
    bit           drain;
  } tx_req_t;

  logic          clk_i;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  htx_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  htx_pkg::out_t out_data_o;

  tx_req_t       tx_q[$];
  htx_pkg::out_t line_bits_q[$];
  logic [15:0]   fcs_reg = htx_pkg::CRC_INIT;
  int unsigned   ones_cnt = 0;
  bit            line_lvl = 1'b1;
  int unsigned   err_cnt = 0;
  int unsigned   gap_cnt = 0;
  int unsigned   stall_cnt = 0;
  int unsigned   cyc_cnt = 0;
  bit            quiet = 1'b0;

  hdlc_tx_framer_nrzi i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 40);
  endfunction

  function automatic void send_bit(input bit b, inout bit [19:0] seq, inout int n);
    if (!b) line_lvl ^= 1'b1;
    seq[n] = line_lvl;
    n++;
  endfunction

  function automatic void send_stuffed(input logic [7:0] v, inout bit [19:0] seq,
                                       inout int n);
    for (int i = 0; i < 8; i++) begin
      send_bit(v[i], seq, n);
      if (v[i]) begin
        ones_cnt++;
        if (ones_cnt >= htx_pkg::STUFF_RUN) begin
          send_bit(1'b0, seq, n);
          ones_cnt = 0;
        end
      end else begin
        ones_cnt = 0;
      end
    end
  endfunction

  // Serial CRC-16 (reflected), one data bit at a time.
  function automatic logic [15:0] fcs_fold(logic [15:0] crc, logic [7:0] v);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ v[i];
      crc = crc >> 1;
      if (fb) crc = crc ^ htx_pkg::CRC_POLY;
    end
    return crc;
  endfunction

  function automatic void encode_item(htx_pkg::in_t it);
    bit [19:0]   seq;
    int          n;
    logic [15:0] fcs_out;
    seq = '0;
    n   = 0;
    if (it.new_packet) line_lvl = 1'b1;
    case (it.func)
      htx_pkg::FUNC_FLAG: begin
        for (int i = 0; i < 8; i++) send_bit(htx_pkg::FLAG_BYTE[i], seq, n);
        ones_cnt = 0;
        fcs_reg  = htx_pkg::CRC_INIT;
      end
      htx_pkg::FUNC_DATA: begin
        fcs_reg = fcs_fold(fcs_reg, it.data_byte);
        send_stuffed(it.data_byte, seq, n);
      end
      htx_pkg::FUNC_FCS: begin
        fcs_out = ~fcs_reg;
        send_stuffed(fcs_out[7:0], seq, n);
        send_stuffed(fcs_out[15:8], seq, n);
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      line_bits_q.push_back('{line_bit: seq[i], last_of_item: (i == n - 1)});
    end
  endfunction

  function automatic void add_req(logic [1:0] func, logic [7:0] data, bit newp, bit drain);
    tx_req_t r;
    r.item.func       = func;
    r.item.data_byte  = data;
    r.item.new_packet = newp;
    r.gap             = quiet ? 0 : pick_gap();
    r.drain           = drain;
    tx_q.push_back(r);
  endfunction

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    tx_req_t r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) encode_item(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          in_valid_i <= 1'b0;
        end else if (tx_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (tx_q[0].drain && line_bits_q.size() != 0) begin
          in_valid_i <= 1'b0;
        end else begin
          r = tx_q.pop_front();
          in_valid_i <= 1'b1;
          in_data_i  <= r.item;
          gap_cnt    = r.gap;
        end
      end
    end
  end

  // Monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    htx_pkg::out_t exp_bit;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      cyc_cnt++;
      if (out_valid_o && out_ready_i) begin
        if (line_bits_q.size() == 0) begin
          $display("%0t: unexpected transaction line_bit=%b last_of_item=%b",
                   $time, out_data_o.line_bit, out_data_o.last_of_item);
          err_cnt++;
        end else begin
          exp_bit = line_bits_q.pop_front();
          if (out_data_o.line_bit !== exp_bit.line_bit) begin
            $display("%0t: line_bit expected %b actual %b",
                     $time, exp_bit.line_bit, out_data_o.line_bit);
            err_cnt++;
          end
          if (out_data_o.last_of_item !== exp_bit.last_of_item) begin
            $display("%0t: last_of_item expected %b actual %b",
                     $time, exp_bit.last_of_item, out_data_o.last_of_item);
            err_cnt++;
          end
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ((cyc_cnt / 400) % 3 != 0 && $urandom_range(0, 5) == 0) stall_cnt = pick_gap();
      end
    end
  end

  initial begin
    int unsigned n_items;
    int unsigned n_frames;
    int unsigned n_data;
    int unsigned r;
    logic [7:0]  d;
    logic [1:0]  f;

    // directed
    add_req(htx_pkg::FUNC_FLAG, 8'h00, 1'b1, 1'b0);
    add_req(htx_pkg::FUNC_FLAG, 8'hFF, 1'b0, 1'b0);
    add_req(htx_pkg::FUNC_DATA, 8'h00, 1'b0, 1'b0);
    add_req(htx_pkg::FUNC_DATA, 8'hFF, 1'b0, 1'b0);
    add_req(htx_pkg::FUNC_DATA, 8'hFF, 1'b0, 1'b0);
    add_req(htx_pkg::FUNC_DATA, 8'h7E, 1'b0, 1'b0);
    add_req(htx_pkg::FUNC_DATA, 8'h1F, 1'b0, 1'b0);
    add_req(htx_pkg::FUNC_DATA, 8'hF8, 1'b0, 1'b0);
    add_req(htx_pkg::FUNC_DATA, 8'h55, 1'b0, 1'b0);
    add_req(htx_pkg::FUNC_DATA, 8'hAA, 1'b1, 1'b0);
    add_req(htx_pkg::FUNC_FCS,  8'h00, 1'b0, 1'b0);
    add_req(FUNC_NONE,          8'hFF, 1'b1, 1'b0);
    add_req(FUNC_NONE,          8'h00, 1'b0, 1'b0);
    add_req(htx_pkg::FUNC_FCS,  8'hFF, 1'b0, 1'b0);
    add_req(htx_pkg::FUNC_FLAG, 8'h00, 1'b1, 1'b1);
    add_req(htx_pkg::FUNC_DATA, 8'h3F, 1'b0, 1'b0);
    add_req(htx_pkg::FUNC_DATA, 8'hFC, 1'b0, 1'b0);
    add_req(htx_pkg::FUNC_FCS,  8'h00, 1'b0, 1'b0);
    add_req(htx_pkg::FUNC_FCS,  8'h00, 1'b1, 1'b0);
    add_req(htx_pkg::FUNC_FLAG, 8'h00, 1'b0, 1'b0);
    add_req(htx_pkg::FUNC_FCS,  8'h00, 1'b0, 1'b0);
    add_req(htx_pkg::FUNC_FLAG, 8'h00, 1'b0, 1'b0);
    n_items  = 20;
    n_frames = 0;

    // random frames with some noise
    while (n_items < 180) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 6) == 0) begin
        r = $urandom_range(1, 4);
        for (int unsigned i = 0; i < r; i++) begin
          f = 2'($urandom_range(0, 3));
          add_req(f, 8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
          if (f != FUNC_NONE) n_items++;
        end
      end else begin
        add_req(htx_pkg::FUNC_FLAG, 8'($urandom), 1'($urandom_range(0, 1)),
                (n_frames % 8) == 3);
        n_data = $urandom_range(0, 6);
        for (int unsigned i = 0; i < n_data; i++) begin
          d = ($urandom_range(0, 2) == 0) ? 8'($urandom | $urandom) : 8'($urandom);
          add_req(htx_pkg::FUNC_DATA, d, $urandom_range(0, 9) == 0, 1'b0);
        end
        if ($urandom_range(0, 9) != 0) begin
          add_req(htx_pkg::FUNC_FCS, 8'($urandom), 1'b0, 1'b0);
          n_items++;
        end
        add_req(htx_pkg::FUNC_FLAG, 8'($urandom), 1'b0, 1'b0);
        n_items += n_data + 2;
        n_frames++;
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (tx_q.size() != 0 || in_valid_i || line_bits_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0 && line_bits_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
